// ===== sv/cpsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpsa_pkg;

  // Received frame, one beat on the input channel
  typedef struct packed {
    logic [10:0] rx_id;
    logic [3:0]  rx_size;
    logic [63:0] rx_data;
  } in_beat_t;

  // Reply, one beat on the result channel
  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [3:0]  tx_size;
    logic [63:0] tx_data;
    logic        store_changed;
    logic        last_result;
  } out_beat_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_NODE_UUID  = 3'd0,
    CFG_VERSION    = 3'd1,
    CFG_TYPE       = 3'd2,
    CFG_REQUEST_ID = 3'd3,
    CFG_SETUP_BASE = 3'd4,
    CFG_REPLY_BASE = 3'd5
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_NAME_RD,
    ST_VAL_RD,
    ST_NAME_WR,
    ST_STORE_WR,
    ST_FINISH
  } state_t;

  // Frame classification
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INFO,
    OP_VALUE,
    OP_NAME,
    OP_STORE
  } op_t;

  localparam int unsigned CFG_W = 16;

  localparam logic [10:0] SETUP_MASK  = 11'h780;
  localparam logic [10:0] INDEX_MASK  = 11'h07F;
  localparam logic [7:0]  GLOBAL_TAG  = 8'hFF;
  localparam logic [7:0]  INFO_TAG    = 8'h20;
  localparam logic [7:0]  NAME_TAG    = 8'h21;
  localparam logic [3:0]  FRAME_BYTES = 4'd8;
  localparam logic [3:0]  INFO_SIZE   = 4'd5;
  localparam logic [3:0]  NAME_SHOWN  = 4'd7;

endpackage

`default_nettype wire

// ===== sv/can_parameter_store_access.sv =====
`timescale 1ns / 1ps
`default_nettype none

// CAN parameter store access. Each beat on the input channel is one received
// CAN frame; the block answers with one or two result beats, the last marked
// by last_result. A request frame returns an info frame and a name frame, or
// one value frame of up to eight store bytes; a setup frame writes the name
// string (index 0) or up to WRITE_MAX store bytes, and reports no reply frame.
// Store and name live in small RAMs, each with one write port and one
// registered read port, walked one byte per cycle by a small sequencer. The
// name walk of an info request stops at the first zero or after seven
// characters; a name write copies at most five characters, since an
// eight-byte frame carries no more, and then a terminating zero. While a
// waiting result beat is stalled by out_stall, the sequencer stays in its
// finish state and takes no new frame. in_stall is low only while the
// sequencer is idle. After reset a clearing pass over max(STORE_BYTES,
// NAME_CHARS + 1) addresses zeroes both RAMs before the first frame is
// taken; configuration writes are taken at any time.
module can_parameter_store_access #(
  parameter int STORE_BYTES = 64,
  parameter int NAME_CHARS  = 16,
  parameter int WRITE_MAX   = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpsa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cpsa_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  import cpsa_pkg::*;

  localparam int SAW        = $clog2(STORE_BYTES);
  localparam int NAME_DEPTH = NAME_CHARS + 1;
  localparam int NAW        = $clog2(NAME_DEPTH);
  localparam int CLR_N      = (STORE_BYTES > NAME_DEPTH) ? STORE_BYTES : NAME_DEPTH;
  localparam int CAW        = $clog2(CLR_N);

  localparam logic [8:0]     STORE_N    = 9'(STORE_BYTES);
  localparam logic [7:0]     STORE_LAST = 8'(STORE_BYTES - 1);
  localparam logic [3:0]     WR_MAX     = 4'(WRITE_MAX);
  localparam logic [NAW-1:0] NAME_LIM   = NAW'(NAME_CHARS);
  localparam logic [CAW-1:0] CLR_LAST   = CAW'(CLR_N - 1);
  localparam logic [CAW:0]   CLR_STORE  = (CAW+1)'(STORE_BYTES);
  localparam logic [CAW:0]   CLR_NAME   = (CAW+1)'(NAME_DEPTH);

  // Configuration registers
  logic [CFG_W-1:0] uuid_r;
  logic [7:0]       version_r;
  logic [7:0]       type_r;
  logic [10:0]      req_id_r;
  logic [10:0]      setup_base_r;
  logic [10:0]      reply_base_r;

  // Sequencer and datapath registers
  state_t          state_r, state_nxt;
  in_beat_t        in_r;
  logic [7:0]      idx_r, idx_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [3:0]      k_r, k_nxt;
  logic [3:0]      from_r, from_nxt;
  logic [NAW-1:0]  n_r, n_nxt;
  logic [CAW-1:0]  clr_r, clr_nxt;
  out_beat_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_beat_t       out_r, out_nxt;

  // RAM ports
  logic           s_wr_en, s_rd_en;
  logic [SAW-1:0] s_wr_addr, s_rd_addr;
  logic [7:0]     s_wr_data, s_rd_data;
  logic           n_wr_en, n_rd_en;
  logic [NAW-1:0] n_wr_addr, n_rd_addr;
  logic [7:0]     n_wr_data, n_rd_data;

  // Decode results
  op_t        op;
  logic [7:0] dec_idx;
  logic [3:0] dec_cnt;
  logic [7:0] b0, b1, b2, b3;
  logic       ident;
  logic [3:0] cnt8;
  logic [3:0] wlen;
  logic [8:0] room;
  logic [7:0] sidx;

  // Datapath helpers
  logic       in_acc;
  logic       out_free;
  logic [7:0] addr_sum;
  logic [2:0] cap_pos;
  logic [7:0] cap_byte;
  logic [2:0] wr_pos;
  logic       name_more;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign b0 = in_r.rx_data[7:0];
  assign b1 = in_r.rx_data[15:8];
  assign b2 = in_r.rx_data[23:16];
  assign b3 = in_r.rx_data[31:24];

  assign addr_sum  = idx_r + {4'b0000, k_r};
  assign cap_pos   = 3'(k_r - 4'd1);
  assign cap_byte  = (k_r == 4'd1 && idx_r == 8'd0) ? version_r : s_rd_data;
  assign wr_pos    = 3'(k_r + 4'd2);
  assign name_more = (from_r < in_r.rx_size) && (n_r < NAME_LIM);

  // Classify the held frame
  always_comb begin
    op      = OP_NONE;
    dec_idx = '0;
    dec_cnt = '0;
    cnt8    = FRAME_BYTES;
    wlen    = '0;
    room    = '0;
    sidx    = {1'b0, in_r.rx_id[6:0]};
    ident   = (in_r.rx_size >= 4'd2) && ({b0, b1} == uuid_r);
    if (in_r.rx_id == req_id_r) begin
      if (in_r.rx_size == 4'd0 || b0 == GLOBAL_TAG) begin
        op = OP_INFO;
      end else if (!ident) begin
        op = OP_NONE;
      end else if (in_r.rx_size == 4'd2) begin
        op = OP_INFO;
      end else if ({1'b0, b2} >= STORE_N) begin
        op = OP_NONE;
      end else begin
        op      = OP_VALUE;
        dec_idx = b2;
        if (in_r.rx_size >= 4'd4 && b3 != 8'd0) begin
          cnt8 = (b3 > 8'd8) ? FRAME_BYTES : b3[3:0];
        end
        room    = STORE_N - {1'b0, b2};
        dec_cnt = ({5'b00000, cnt8} > room) ? room[3:0] : cnt8;
      end
    end else if ((in_r.rx_id & SETUP_MASK) == setup_base_r && ident) begin
      if (sidx == 8'd0) begin
        op = OP_NAME;
      end else if ({1'b0, sidx} >= STORE_N || in_r.rx_size < 4'd3) begin
        op = OP_NONE;
      end else begin
        op      = OP_STORE;
        dec_idx = sidx;
        wlen    = in_r.rx_size - 4'd2;
        if (wlen > WR_MAX) begin
          wlen = WR_MAX;
        end
        room    = STORE_N - {1'b0, sidx};
        dec_cnt = ({5'b00000, wlen} > room) ? room[3:0] : wlen;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (op)
          OP_VALUE: state_nxt = ST_VAL_RD;
          OP_NAME:  state_nxt = ST_NAME_WR;
          OP_STORE: state_nxt = ST_STORE_WR;
          default:  state_nxt = ST_FINISH;
        endcase
      end
      ST_NAME_RD: begin
        if (k_r != 4'd0 && (n_rd_data == 8'd0 || k_r == NAME_SHOWN)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_VAL_RD: begin
        if (k_r == cnt_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_NAME_WR: begin
        if (!name_more) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_STORE_WR: begin
        if (k_r == cnt_r - 4'd1) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = res_r.last_result ? ST_IDLE : ST_NAME_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    from_nxt      = from_r;
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    s_wr_en       = 1'b0;
    s_wr_addr     = '0;
    s_wr_data     = '0;
    s_rd_en       = 1'b0;
    s_rd_addr     = '0;
    n_wr_en       = 1'b0;
    n_wr_addr     = '0;
    n_wr_data     = '0;
    n_rd_en       = 1'b0;
    n_rd_addr     = '0;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        s_wr_en   = ({1'b0, clr_r} < CLR_STORE);
        s_wr_addr = SAW'(clr_r);
        n_wr_en   = ({1'b0, clr_r} < CLR_NAME);
        n_wr_addr = NAW'(clr_r);
        clr_nxt   = clr_r + 1'b1;
      end
      ST_DECODE: begin
        idx_nxt  = dec_idx;
        cnt_nxt  = dec_cnt;
        k_nxt    = '0;
        n_nxt    = '0;
        from_nxt = (in_r.rx_size >= 4'd4) ? 4'd3 : 4'd2;
        res_nxt  = '0;
        res_nxt.last_result = 1'b1;
        case (op)
          OP_INFO: begin
            res_nxt.tx_valid    = 1'b1;
            res_nxt.tx_id       = reply_base_r;
            res_nxt.tx_size     = INFO_SIZE;
            res_nxt.tx_data     = {24'd0, type_r, version_r, 8'd0, INFO_TAG, STORE_LAST};
            res_nxt.last_result = 1'b0;
          end
          OP_VALUE: begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_id    = reply_base_r | ({3'b000, dec_idx} & INDEX_MASK);
            res_nxt.tx_size  = dec_cnt;
          end
          OP_NAME, OP_STORE: begin
            res_nxt.store_changed = 1'b1;
          end
          default: begin
            res_nxt.last_result = 1'b1;
          end
        endcase
      end
      ST_NAME_RD: begin
        // Issue the next name read and capture the previous one
        n_rd_en   = (k_r < NAME_SHOWN);
        n_rd_addr = NAW'(k_r);
        if (k_r == 4'd0) begin
          k_nxt = k_r + 4'd1;
        end else if (n_rd_data == 8'd0) begin
          res_nxt.tx_size = k_r;
        end else begin
          res_nxt.tx_data[{k_r[2:0], 3'b000} +: 8] = n_rd_data;
          if (k_r == NAME_SHOWN) begin
            res_nxt.tx_size = FRAME_BYTES;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end
      end
      ST_VAL_RD: begin
        s_rd_en   = (k_r < cnt_r);
        s_rd_addr = addr_sum[SAW-1:0];
        if (k_r != 4'd0) begin
          res_nxt.tx_data[{cap_pos, 3'b000} +: 8] = cap_byte;
        end
        k_nxt = k_r + 4'd1;
      end
      ST_NAME_WR: begin
        // Copy one character, then the terminating zero
        n_wr_en   = 1'b1;
        n_wr_addr = n_r;
        if (name_more) begin
          n_wr_data = in_r.rx_data[{from_r[2:0], 3'b000} +: 8];
          n_nxt     = n_r + 1'b1;
          from_nxt  = from_r + 4'd1;
        end
      end
      ST_STORE_WR: begin
        s_wr_en   = 1'b1;
        s_wr_addr = addr_sum[SAW-1:0];
        s_wr_data = in_r.rx_data[{wr_pos, 3'b000} +: 8];
        k_nxt     = k_r + 4'd1;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          // Prepare the name frame that follows the first info frame
          if (!res_r.last_result) begin
            res_nxt             = '0;
            res_nxt.tx_valid    = 1'b1;
            res_nxt.tx_id       = reply_base_r;
            res_nxt.tx_size     = 4'd1;
            res_nxt.tx_data     = {56'd0, NAME_TAG};
            res_nxt.last_result = 1'b1;
            k_nxt               = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uuid_r       <= '0;
      version_r    <= '0;
      type_r       <= '0;
      req_id_r     <= '0;
      setup_base_r <= '0;
      reply_base_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_NODE_UUID:  uuid_r       <= cfg_wdata;
        CFG_VERSION:    version_r    <= cfg_wdata[7:0];
        CFG_TYPE:       type_r       <= cfg_wdata[7:0];
        CFG_REQUEST_ID: req_id_r     <= cfg_wdata[10:0];
        CFG_SETUP_BASE: setup_base_r <= cfg_wdata[10:0];
        CFG_REPLY_BASE: reply_base_r <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r.rx_id   <= in_data.rx_id;
      in_r.rx_size <= (in_data.rx_size > FRAME_BYTES) ? FRAME_BYTES : in_data.rx_size;
      in_r.rx_data <= in_data.rx_data;
    end
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    from_r <= from_nxt;
    n_r    <= n_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // Parameter store
  cpsa_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store_ram (
    .clk     (clk),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data),
    .rd_en   (s_rd_en),
    .rd_addr (s_rd_addr),
    .rd_data (s_rd_data)
  );

  // Name string
  cpsa_ram #(
    .WIDTH (8),
    .DEPTH (NAME_DEPTH)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (n_wr_en),
    .wr_addr (n_wr_addr),
    .wr_data (n_wr_data),
    .rd_en   (n_rd_en),
    .rd_addr (n_rd_addr),
    .rd_data (n_rd_data)
  );

endmodule

`default_nettype wire

// ===== sv/cpsa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
